>>> src/nngt_pkg.sv
// ----------------------------------------------------------------------------
// nngt_pkg
// Shared types and constants for the nearest-node graph table: word formats,
// request and status codes, sequencer states and distance types.
// ----------------------------------------------------------------------------
package nngt_pkg;

   localparam int MAX_NODES  = 64;
   localparam int COORD_BITS = 12;
   localparam int IDX_W      = $clog2(MAX_NODES);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int EDGE_W     = 16;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int DIST_W     = SQ_W + 1;
   localparam int NODE_W     = 2 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [EDGE_W-1:0]     edge_cnt_type;
   typedef logic [DIST_W-1:0]     dist_type;
   typedef logic [MAX_NODES-1:0]  row_type;

   localparam logic [2:0] REQ_ADD_NODE   = 3'd0;
   localparam logic [2:0] REQ_EDGE_IDX   = 3'd1;
   localparam logic [2:0] REQ_EDGE_PTS   = 3'd2;
   localparam logic [2:0] REQ_NEAREST    = 3'd3;
   localparam logic [2:0] REQ_TEST_EDGE  = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   localparam edge_cnt_type EDGE_MAX = '1;

   typedef struct packed {
      logic [2:0] req_type;
      coord_type  coord_x;
      coord_type  coord_y;
      coord_type  coord_x2;
      coord_type  coord_y2;
      idx_type    index_a;
      idx_type    index_b;
   } req_word_type;

   typedef struct packed {
      idx_type      result_a;
      idx_type      result_b;
      logic         edge_present;
      cnt_type      node_total;
      edge_cnt_type edge_total;
      logic [1:0]   status;
   } rsp_word_type;

   // tag that rides along the distance pipeline
   typedef struct packed {
      logic    valid;
      idx_type idx;
   } dist_tag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LINK_RD_A,
      ST_LINK_WR_A,
      ST_LINK_RD_B,
      ST_LINK_WR_B,
      ST_TEST_RD,
      ST_TEST_CHK,
      ST_FINISH
   } state_type;

endpackage

>>> src/nearest_node_graph_table_core.sv
// Add node, failed and unused requests go straight to the result; edge by
// indices reads and writes row a, then row b; test edge reads row a and checks
// bit b; nearest query scans every node, one node per cycle through the
// distance unit; edge by points scans twice, then links as by indices. One
// request in flight; the next is taken once the result is in the output reg.
// Synchronous reset clears counts, adjacency row valid bits and the handshake.
// ----------------------------------------------------------------------------
// nearest_node_graph_table_core
// Node coordinate table with symmetric adjacency matrix, nearest-node search
// by linear scan through a shared distance unit.
// ----------------------------------------------------------------------------
module nearest_node_graph_table_core import nngt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   // storage
   logic [NODE_W-1:0] node_mem [MAX_NODES];
   row_type           adj_mem  [MAX_NODES];
   row_type           adj_vld_ff;
   logic [NODE_W-1:0] node_rd_ff;
   row_type           adj_rd_ff;
   logic              adj_rd_vld_ff;

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   idx_type      ra_ff, ra_in, rb_ff, rb_in;
   logic         ep_ff, ep_in;
   logic [1:0]   st_ff, st_in;
   cnt_type      node_count_ff, node_count_in;
   edge_cnt_type edge_count_ff, edge_count_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         issue_on_ff, issue_on_in;
   idx_type      issue_addr_ff, issue_addr_in;
   logic         pass_ff, pass_in;
   dist_tag_type mem_tag_ff, mem_tag_in;
   dist_type     best_dist_ff, best_dist_in;
   idx_type      best_idx_ff, best_idx_in;

   logic         node_we;
   logic         adj_we;
   idx_type      adj_waddr, adj_raddr;
   row_type      adj_wdata, adj_row;
   idx_type      last_idx, final_idx;
   logic         upd;
   dist_tag_type d_tag;
   dist_type     d_dist;
   coord_type    pt_x, pt_y;

   assign adj_row   = adj_rd_vld_ff ? adj_rd_ff : '0;
   assign last_idx  = IDX_W'(node_count_ff - CNT_W'(1));
   assign pt_x      = pass_ff ? req_ff.coord_x2 : req_ff.coord_x;
   assign pt_y      = pass_ff ? req_ff.coord_y2 : req_ff.coord_y;
   assign upd       = d_tag.valid && (d_tag.idx == '0 || d_dist < best_dist_ff);
   assign final_idx = upd ? d_tag.idx : best_idx_ff;

   nngt_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (mem_tag_ff),
      .node_x   (node_rd_ff[NODE_W-1:COORD_BITS]),
      .node_y   (node_rd_ff[COORD_BITS-1:0]),
      .pt_x     (pt_x),
      .pt_y     (pt_y),
      .out_tag  (d_tag),
      .out_dist (d_dist)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      ep_in         = ep_ff;
      st_in         = st_ff;
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      issue_on_in   = issue_on_ff;
      issue_addr_in = issue_addr_ff;
      pass_in       = pass_ff;
      mem_tag_in    = '{valid: 1'b0, idx: issue_addr_ff};
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      node_we       = 1'b0;
      adj_we        = 1'b0;
      adj_waddr     = ra_ff;
      adj_wdata     = adj_row;
      adj_raddr     = ra_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               ra_in    = '0;
               rb_in    = '0;
               ep_in    = 1'b0;
               st_in    = STAT_OK;
               state_in = ST_FINISH;
               case (req_data.req_type)
                  REQ_ADD_NODE: begin
                     if (node_count_ff >= CNT_W'(MAX_NODES)) begin
                        st_in = STAT_FULL;
                     end else begin
                        node_we       = 1'b1;
                        ra_in         = node_count_ff[IDX_W-1:0];
                        node_count_in = node_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_EDGE_IDX, REQ_TEST_EDGE: begin
                     if ({1'b0, req_data.index_a} >= node_count_ff ||
                         {1'b0, req_data.index_b} >= node_count_ff) begin
                        st_in = STAT_RANGE;
                     end else begin
                        ra_in    = req_data.index_a;
                        rb_in    = req_data.index_b;
                        state_in = (req_data.req_type == REQ_EDGE_IDX) ?
                                   ST_LINK_RD_A : ST_TEST_RD;
                     end
                  end
                  REQ_EDGE_PTS, REQ_NEAREST: begin
                     if (node_count_ff == '0) begin
                        st_in = STAT_EMPTY;
                     end else begin
                        issue_on_in   = 1'b1;
                        issue_addr_in = '0;
                        pass_in       = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_on_ff) begin
               mem_tag_in.valid = 1'b1;
               if (issue_addr_ff == last_idx) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_addr_in = issue_addr_ff + IDX_W'(1);
               end
            end
            if (upd) begin
               best_dist_in = d_dist;
               best_idx_in  = d_tag.idx;
            end
            // last node out of the pipe closes the pass
            if (d_tag.valid && d_tag.idx == last_idx) begin
               if (req_ff.req_type == REQ_NEAREST) begin
                  ra_in    = final_idx;
                  state_in = ST_FINISH;
               end else if (!pass_ff) begin
                  ra_in         = final_idx;
                  pass_in       = 1'b1;
                  issue_on_in   = 1'b1;
                  issue_addr_in = '0;
               end else begin
                  rb_in    = final_idx;
                  state_in = ST_LINK_RD_A;
               end
            end
         end
         ST_LINK_RD_A: begin
            adj_raddr = ra_ff;
            state_in  = ST_LINK_WR_A;
         end
         ST_LINK_WR_A: begin
            adj_we    = 1'b1;
            adj_waddr = ra_ff;
            adj_wdata = adj_row | (row_type'(1) << rb_ff);
            state_in  = ST_LINK_RD_B;
         end
         ST_LINK_RD_B: begin
            // read issued after row a is written, so a self loop sees it
            adj_raddr = rb_ff;
            state_in  = ST_LINK_WR_B;
         end
         ST_LINK_WR_B: begin
            adj_we    = 1'b1;
            adj_waddr = rb_ff;
            adj_wdata = adj_row | (row_type'(1) << ra_ff);
            if (edge_count_ff != EDGE_MAX) begin
               edge_count_in = edge_count_ff + EDGE_W'(1);
            end
            state_in = ST_FINISH;
         end
         ST_TEST_RD: begin
            adj_raddr = ra_ff;
            state_in  = ST_TEST_CHK;
         end
         ST_TEST_CHK: begin
            ep_in    = adj_row[rb_ff];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_a     = ra_ff;
               rsp_in.result_b     = rb_ff;
               rsp_in.edge_present = ep_ff;
               rsp_in.node_total   = node_count_ff;
               rsp_in.edge_total   = edge_count_ff;
               rsp_in.status       = st_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      mem_tag_ff.idx <= mem_tag_in.idx;
      if (reset) begin
         state_ff         <= ST_IDLE;
         node_count_ff    <= '0;
         edge_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         issue_on_ff      <= 1'b0;
         mem_tag_ff.valid <= 1'b0;
         adj_vld_ff       <= '0;
      end else begin
         state_ff         <= state_in;
         node_count_ff    <= node_count_in;
         edge_count_ff    <= edge_count_in;
         rsp_valid_ff     <= rsp_valid_in;
         issue_on_ff      <= issue_on_in;
         mem_tag_ff.valid <= mem_tag_in.valid;
         if (adj_we) begin
            adj_vld_ff[adj_waddr] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      ra_ff          <= ra_in;
      rb_ff          <= rb_in;
      ep_ff          <= ep_in;
      st_ff          <= st_in;
      rsp_ff         <= rsp_in;
      issue_addr_ff  <= issue_addr_in;
      pass_ff        <= pass_in;
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
   end

   // node coordinate memory
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_count_ff[IDX_W-1:0]] <= {req_data.coord_x, req_data.coord_y};
      end
      node_rd_ff <= node_mem[issue_addr_ff];
   end

   // adjacency memory; rows never written read as zero
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      adj_rd_ff     <= adj_mem[adj_raddr];
      adj_rd_vld_ff <= adj_vld_ff[adj_raddr];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= CNT_W'(MAX_NODES))
      else $error("node count above table size");

   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      d_tag.valid |-> state_ff == ST_SCAN)
      else $error("distance result outside a scan");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> state_ff == ST_FINISH)
      else $error("result word overwritten while stalled");

   a_edge_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> edge_count_ff >= $past(edge_count_ff))
      else $error("edge count went down");
`endif

endmodule

>>> src/nngt_dist.sv
// ----------------------------------------------------------------------------
// nngt_dist
// Squared Euclidean distance unit, three stages: absolute differences,
// squares, sum. One node enters per cycle; the tag travels alongside.
// ----------------------------------------------------------------------------
module nngt_dist import nngt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dist_tag_type in_tag,
   input  coord_type    node_x,
   input  coord_type    node_y,
   input  coord_type    pt_x,
   input  coord_type    pt_y,
   output dist_tag_type out_tag,
   output dist_type     out_dist
);

   dist_tag_type    tag1_ff, tag2_ff, tag3_ff;
   coord_type       dx_ff, dy_ff;
   logic [SQ_W-1:0] sqx_ff, sqy_ff;
   dist_type        sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= in_tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag1_ff.idx <= in_tag.idx;
      tag2_ff.idx <= tag1_ff.idx;
      tag3_ff.idx <= tag2_ff.idx;
      dx_ff  <= (node_x > pt_x) ? (node_x - pt_x) : (pt_x - node_x);
      dy_ff  <= (node_y > pt_y) ? (node_y - pt_y) : (pt_y - node_y);
      sqx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sum_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   assign out_tag  = tag3_ff;
   assign out_dist = sum_ff;

endmodule
